/* hw/rtl/dhp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_pkg
// shared types, constants and the checksum step of the directory header parser
// ----------------------------------------------------------------------------
package dhp_pkg;

   // defaults for the top-level parameters
   localparam int SECTOR_BYTES_DEF = 32;
   localparam int NAME_MAX_DEF     = 10;
   localparam int QUEUE_DEPTH_DEF  = 4;

   // header layout
   localparam int MAGIC_LEN   = 4;
   localparam int ALLOC_END   = 7;
   localparam int FIXED_BYTES = 10;
   localparam int HDR_BASE    = 13;
   localparam int POS_W       = $clog2(FIXED_BYTES);

   localparam logic [7:0] HDR_MAGIC [MAGIC_LEN] = '{8'h53, 8'h44, 8'h66, 8'h73};

   // field widths
   localparam int LEN_W      = 24;
   localparam int NCNT_W     = 4;
   localparam int OFS_W      = 5;
   localparam int SECT_W     = 20;
   // name count carried between front and back, wide enough for the largest name limit
   localparam int JOB_CNT_W  = 7;

   // checksum
   localparam logic [15:0] CK_INIT  = 16'd3456;
   // ceil(2^19 / 7), exact v/7 for every 16-bit v
   localparam logic [16:0] CK_RECIP = 17'd74899;
   localparam int          CK_SHIFT = 19;

   // result kinds
   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_HEADER = 1'b1;

   // header status codes
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_BAD_MAGIC   = 2'd1;
   localparam logic [1:0] ST_NAME_UNTERM = 2'd2;
   localparam logic [1:0] ST_CK_MISMATCH = 2'd3;

   // classified work handed from front to back
   typedef struct packed {
      logic                 kind;
      logic [7:0]           name_char;
      logic [1:0]           status;
      logic [LEN_W-1:0]     alloc;
      logic [LEN_W-1:0]     len;
      logic [JOB_CNT_W-1:0] cnt;
      logic                 full;
   } job_type;

   // one result beat
   typedef struct packed {
      logic              kind;
      logic [7:0]        name_char;
      logic [1:0]        status;
      logic [LEN_W-1:0]  alloc_sectors;
      logic [LEN_W-1:0]  file_bytes;
      logic [NCNT_W-1:0] name_count;
      logic [OFS_W-1:0]  data_offset;
      logic [SECT_W-1:0] sectors_in_use;
   } rsp_type;

   // v = v/7 + v*12 + b, mod 2^16
   function automatic logic [15:0] dhp_sum_update(input logic [15:0] v, input logic [7:0] b);
      logic [32:0] prod;
      logic [13:0] quot;
      prod = {17'b0, v} * {16'b0, CK_RECIP};
      quot = prod[CK_SHIFT +: 14];
      return {2'b0, quot} + {v[12:0], 3'b0} + {v[13:0], 2'b0} + {8'b0, b};
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/dhp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_front
// byte parser: tracks the header layout, checksum and name, emits work items
// ----------------------------------------------------------------------------
module dhp_front #(
   parameter int NAME_MAX = dhp_pkg::NAME_MAX_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [7:0]       in_byte,
   input  wire logic             in_start,
   input  wire logic             job_room,
   output logic                  job_valid,
   output dhp_pkg::job_type      job
);
   import dhp_pkg::*;

   localparam int NW = $clog2(NAME_MAX + 1);

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_FIXED = 5'b00010,
      PH_NAME  = 5'b00100,
      PH_CKHI  = 5'b01000,
      PH_CKLO  = 5'b10000
   } phase_type;

   phase_type          phase_ff, phase_in, phase_e;
   logic [POS_W-1:0]   pos_ff, pos_in, pos_e;
   logic [LEN_W-1:0]   alloc_ff, alloc_in, alloc_e;
   logic [LEN_W-1:0]   len_ff, len_in, len_e;
   logic [15:0]        sum_ff, sum_in, sum_e, sum_next;
   logic [NW-1:0]      cnt_ff, cnt_in, cnt_e;
   logic [7:0]         hi_ff, hi_in, hi_e;
   logic               beat;

   assign in_ready = job_room;
   assign beat     = in_valid & job_room;

   // a start flag restarts the parse with this byte as byte 0
   always_comb begin
      if (in_start) begin
         phase_e = PH_FIXED;
         pos_e   = '0;
         alloc_e = '0;
         len_e   = '0;
         sum_e   = CK_INIT;
         cnt_e   = '0;
         hi_e    = '0;
      end else begin
         phase_e = phase_ff;
         pos_e   = pos_ff;
         alloc_e = alloc_ff;
         len_e   = len_ff;
         sum_e   = sum_ff;
         cnt_e   = cnt_ff;
         hi_e    = hi_ff;
      end
   end

   assign sum_next = dhp_sum_update(sum_e, in_byte);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      alloc_in  = alloc_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      hi_in     = hi_ff;
      job_valid = 1'b0;
      job       = '0;
      if (beat) begin
         phase_in = phase_e;
         pos_in   = pos_e;
         alloc_in = alloc_e;
         len_in   = len_e;
         sum_in   = sum_e;
         cnt_in   = cnt_e;
         hi_in    = hi_e;
         unique case (phase_e)
            PH_IDLE: begin
            end
            PH_FIXED: begin
               if ((pos_e < POS_W'(MAGIC_LEN)) &&
                   (in_byte != HDR_MAGIC[pos_e[1:0]])) begin
                  job_valid  = 1'b1;
                  job.kind   = KIND_HEADER;
                  job.status = ST_BAD_MAGIC;
                  phase_in   = PH_IDLE;
               end else begin
                  if (pos_e >= POS_W'(ALLOC_END)) begin
                     len_in = {len_e[LEN_W-9:0], in_byte};
                  end else if (pos_e >= POS_W'(MAGIC_LEN)) begin
                     alloc_in = {alloc_e[LEN_W-9:0], in_byte};
                  end
                  sum_in = sum_next;
                  pos_in = pos_e + POS_W'(1);
                  if (pos_e == POS_W'(FIXED_BYTES - 1)) begin
                     phase_in = PH_NAME;
                     cnt_in   = '0;
                  end
               end
            end
            PH_NAME: begin
               if (in_byte == 8'd0) begin
                  phase_in = PH_CKHI;
               end else if (cnt_e >= NW'(NAME_MAX)) begin
                  job_valid  = 1'b1;
                  job.kind   = KIND_HEADER;
                  job.status = ST_NAME_UNTERM;
                  job.alloc  = alloc_e;
                  job.len    = len_e;
                  phase_in   = PH_IDLE;
               end else begin
                  sum_in        = sum_next;
                  cnt_in        = cnt_e + NW'(1);
                  job_valid     = 1'b1;
                  job.kind      = KIND_CHAR;
                  job.name_char = in_byte;
               end
            end
            PH_CKHI: begin
               hi_in = in_byte;
               if (in_byte != sum_e[15:8]) begin
                  job_valid  = 1'b1;
                  job.kind   = KIND_HEADER;
                  job.status = ST_CK_MISMATCH;
                  job.alloc  = alloc_e;
                  job.len    = len_e;
                  job.cnt    = JOB_CNT_W'(cnt_e);
                  job.full   = 1'b1;
                  phase_in   = PH_IDLE;
               end else begin
                  phase_in = PH_CKLO;
               end
            end
            PH_CKLO: begin
               job_valid  = 1'b1;
               job.kind   = KIND_HEADER;
               job.status = ({hi_e, in_byte} == sum_e) ? ST_OK : ST_CK_MISMATCH;
               job.alloc  = alloc_e;
               job.len    = len_e;
               job.cnt    = JOB_CNT_W'(cnt_e);
               job.full   = 1'b1;
               phase_in   = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         alloc_ff <= '0;
         len_ff   <= '0;
         sum_ff   <= CK_INIT;
         cnt_ff   <= '0;
         hi_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         alloc_ff <= alloc_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         hi_ff    <= hi_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/dhp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_queue
// short first-in first-out queue of work items between front and back
// ----------------------------------------------------------------------------
module dhp_queue #(
   parameter int DEPTH = dhp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire dhp_pkg::job_type push_data,
   output logic                  push_room,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output dhp_pkg::job_type      pop_data
);
   import dhp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_room = (count_ff != CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign push      = push_valid & push_room;
   assign pop       = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/dhp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_back
// result pipeline: sector count by reciprocal multiply, result formatting
// ----------------------------------------------------------------------------
module dhp_back #(
   parameter int SECTOR_BYTES = dhp_pkg::SECTOR_BYTES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   output logic                  job_ready,
   input  wire dhp_pkg::job_type job,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output dhp_pkg::rsp_type      out_rsp
);
   import dhp_pkg::*;

   // header plus data plus rounding term always fits in SUM_W bits
   localparam int SUM_W  = $clog2((1 << LEN_W) + HDR_BASE + (1 << JOB_CNT_W) + SECTOR_BYTES);
   localparam int DIV_SH = SUM_W + $clog2(SECTOR_BYTES);
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   // ceil(2^DIV_SH / SECTOR_BYTES): exact floor division for every SUM_W-bit value
   localparam longint unsigned RECIP =
      ((64'd1 << DIV_SH) + SECTOR_BYTES - 1) / SECTOR_BYTES;
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
   localparam logic [SUM_W-1:0]   ROUND_ADD = SUM_W'(HDR_BASE + SECTOR_BYTES - 1);

   logic                s1_v_ff, s2_v_ff, s3_v_ff;
   job_type             s1_job_ff, s2_job_ff;
   logic [SUM_W-1:0]    s1_y_ff, s1_y_in;
   logic [PROD_W-1:0]   s2_prod_ff, s2_prod_in;
   rsp_type             s3_rsp_ff, s3_rsp_in;
   logic                rdy1, rdy2, rdy3;
   logic                in_use;

   assign rdy3      = !s3_v_ff || out_ready;
   assign rdy2      = !s2_v_ff || rdy3;
   assign rdy1      = !s1_v_ff || rdy2;
   assign job_ready = rdy1;

   assign s1_y_in    = SUM_W'(job.cnt) + SUM_W'(job.len) + ROUND_ADD;
   assign s2_prod_in = {{RECIP_W{1'b0}}, s1_y_ff} * {{SUM_W{1'b0}}, RECIP_V};

   // empty name and empty length count as no sectors in use
   assign in_use = s2_job_ff.full &&
                   !((s2_job_ff.cnt == '0) && (s2_job_ff.len == '0));

   always_comb begin
      s3_rsp_in                = '0;
      s3_rsp_in.kind           = s2_job_ff.kind;
      s3_rsp_in.name_char      = s2_job_ff.name_char;
      s3_rsp_in.status         = s2_job_ff.status;
      s3_rsp_in.alloc_sectors  = s2_job_ff.alloc;
      s3_rsp_in.file_bytes     = s2_job_ff.len;
      if (s2_job_ff.full) begin
         s3_rsp_in.name_count  = NCNT_W'(s2_job_ff.cnt);
         s3_rsp_in.data_offset = OFS_W'(s2_job_ff.cnt) + OFS_W'(HDR_BASE);
      end
      if (in_use) begin
         s3_rsp_in.sectors_in_use = SECT_W'(s2_prod_ff >> DIV_SH);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && job_valid) begin
         s1_job_ff <= job;
         s1_y_ff   <= s1_y_in;
      end
      if (rdy2 && s1_v_ff) begin
         s2_job_ff  <= s1_job_ff;
         s2_prod_ff <= s2_prod_in;
      end
      if (rdy3 && s2_v_ff) begin
         s3_rsp_ff <= s3_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_v_ff <= job_valid;
         end
         if (rdy2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (rdy3) begin
            s3_v_ff <= s2_v_ff;
         end
      end
   end

   assign out_valid = s3_v_ff;
   assign out_rsp   = s3_rsp_ff;

endmodule
`default_nettype wire

/* hw/rtl/directory_header_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// directory_header_parser
// streaming parser for the directory header at the start of a storage sector
// ----------------------------------------------------------------------------
// Takes one sector byte per beat, with req_tuser set on byte 0 of a sector,
// which restarts any parse under way. Checks the four magic bytes, decodes the
// 24-bit allocation count and byte length, passes each name character out as
// a beat (rsp_tuser low) and closes with one header beat (rsp_tuser high)
// carrying status and, as far as the parse got, decoded fields, data offset
// and sectors in use. Bytes after the header and bytes without a preceding
// start flag give no beat. A byte is accepted on every cycle while the
// four-entry work queue has room, so the block sustains one byte per cycle;
// a byte's work item is registered in the queue and then passes the
// three-stage result pipeline around the sector-count multiplier, whose last
// stage is the output register. There is no clearing pass after reset.
module directory_header_parser #(
   parameter int SECTOR_BYTES = dhp_pkg::SECTOR_BYTES_DEF,
   parameter int NAME_MAX     = dhp_pkg::NAME_MAX_DEF,
   parameter int QUEUE_DEPTH  = dhp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // in_byte [7:0]
   input  wire logic        req_tuser,   // sector_start
   // result output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,   // name_char [7:0], header_status [9:8],
                                         // alloc_sectors [33:10], file_bytes [57:34],
                                         // name_count [61:58], data_offset [66:62],
                                         // sectors_in_use [86:67], zero [87]
   output logic             rsp_tuser    // item_kind
);
   import dhp_pkg::*;

   // front to queue
   logic    fr_job_valid;
   job_type fr_job;
   logic    q_room;

   // queue to back
   logic    q_valid;
   logic    q_ready;
   job_type q_job;

   // back to output
   rsp_type bk_rsp;

   // parser front: classifies each byte, builds work items
   dhp_front #(
      .NAME_MAX (NAME_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_start  (req_tuser),
      .job_room  (q_room),
      .job_valid (fr_job_valid),
      .job       (fr_job)
   );

   // decouples byte intake from output back-pressure
   dhp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_job_valid),
      .push_data  (fr_job),
      .push_room  (q_room),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_job)
   );

   // result pipeline: sector count and output register
   dhp_back #(
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_ready (q_ready),
      .job       (q_job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (bk_rsp)
   );

   // pack the result beat, first field in the lowest bits
   assign rsp_tuser = bk_rsp.kind;
   assign rsp_tdata = {1'b0,
                       bk_rsp.sectors_in_use,
                       bk_rsp.data_offset,
                       bk_rsp.name_count,
                       bk_rsp.file_bytes,
                       bk_rsp.alloc_sectors,
                       bk_rsp.status,
                       bk_rsp.name_char};

   // a name character beat carries nothing but the character
   a_char_beat_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_CHAR)) |-> (rsp_tdata[87:8] == '0))
      else $error("name character beat carries header fields");

   // bad magic gives a header with no decoded fields
   a_bad_magic_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_HEADER) && (bk_rsp.status == ST_BAD_MAGIC))
      |-> (rsp_tdata[87:10] == '0))
      else $error("bad magic header carries decoded fields");

   // an unterminated name gives no count, offset or sector figure
   a_unterm_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_HEADER) && (bk_rsp.status == ST_NAME_UNTERM))
      |-> ((bk_rsp.name_count == '0) && (bk_rsp.data_offset == '0) &&
           (bk_rsp.sectors_in_use == '0)))
      else $error("unterminated name header carries name figures");

   // a work item is only produced on an accepted byte
   a_job_on_beat: assert property (@(posedge clock) disable iff (reset)
      fr_job_valid |-> (req_tvalid && req_tready))
      else $error("work item without an accepted byte");

endmodule
`default_nettype wire

/* verif/directory_header_parser_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// directory_header_parser_test
// self-checking stream test of the directory header parser
// ----------------------------------------------------------------------------
// Feeds whole sector headers, damaged headers, cut-short headers and random
// noise into the byte stream. Every accepted byte goes through a local model
// of the parse, which queues the name character and header beats it should
// cause. Each result beat is checked field by field against the oldest of
// those. Both sides idle in short random bursts, save in the last stretch.
// Once the receiver holds off for a long stretch so that the block backs up.
// The sender also waits for the block to drain between phases.
// ----------------------------------------------------------------------------
module directory_header_parser_test;
   import dhp_pkg::*;

   localparam int SECTOR_BYTES = SECTOR_BYTES_DEF;
   localparam int NAME_MAX     = NAME_MAX_DEF;
   localparam int ITEM_GOAL    = 1350;
   localparam int HOLD_CYCLES  = 100;
   localparam int CYCLE_LIMIT  = 200000;

   // parse phases of the local model
   typedef enum logic [2:0] {PH_IDLE, PH_FIXED, PH_NAME, PH_CKHI, PH_CKLO} parse_phase_type;

   // ways of damaging a generated header
   typedef enum int {
      FLT_NONE, FLT_MAGIC, FLT_UNTERM, FLT_CK_HI, FLT_CK_LO, FLT_CUT
   } fault_kind_type;

   // one byte waiting to go out on the input stream
   typedef struct {
      logic [7:0] data;
      logic       start;
   } raw_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // in_byte [7:0]
   logic        req_tuser = 1'b0;    // sector_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;           // name_char [7:0], header_status [9:8],
                                     // alloc_sectors [33:10], file_bytes [57:34],
                                     // name_count [61:58], data_offset [66:62],
                                     // sectors_in_use [86:67], zero [87]
   logic        rsp_tuser;           // item_kind

   directory_header_parser #(
      .SECTOR_BYTES(SECTOR_BYTES),
      .NAME_MAX    (NAME_MAX)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // stimulus and checking bookkeeping
   raw_byte_type pending_bytes[$];
   raw_byte_type next_beat;
   rsp_type     expected_results[$];
   int          fed_bytes = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          req_fire = 1'b0;
   bit          idle_on = 1'b1;
   int          send_gap = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   int          holds_asked = 0;
   int          holds_granted = 0;

   // local copy of the parse state
   parse_phase_type phase = PH_IDLE;
   int           fixed_pos = 0;
   logic [23:0]  alloc_acc = '0;
   logic [23:0]  length_acc = '0;
   logic [15:0]  run_sum = CK_INIT;
   int           name_cnt = 0;
   logic [7:0]   sum_hi = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   // checksum step: v/7 + 12v + byte, kept to 16 bits
   function automatic logic [15:0] checksum_step(input logic [15:0] v, input logic [7:0] b);
      return 16'(v / 7 + v * 12 + b);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s got %0h want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // header beat that closes the parse; full and decoded pick which fields it carries
   task automatic close_header(input logic [1:0] status, input bit full, input bit decoded);
      rsp_type     r;
      int unsigned span;
      r = '0;
      r.kind = KIND_HEADER;
      r.status = status;
      if (decoded) begin
         r.alloc_sectors = alloc_acc;
         r.file_bytes = length_acc;
      end
      if (full) begin
         r.name_count = NCNT_W'(name_cnt);
         r.data_offset = OFS_W'(name_cnt + HDR_BASE);
         // empty name and zero length use no sectors at all
         if (name_cnt != 0 || length_acc != 0) begin
            span = HDR_BASE + name_cnt + length_acc;
            r.sectors_in_use = SECT_W'((span + SECTOR_BYTES - 1) / SECTOR_BYTES);
         end
      end
      expected_results.push_back(r);
      phase = PH_IDLE;
   endtask

   // advance the model by one accepted byte and queue what it should produce
   task automatic parse_byte(input logic [7:0] b, input logic start);
      rsp_type r;
      // a start flag drops whatever parse is under way
      if (start) begin
         fixed_pos = 0;
         phase = PH_FIXED;
         alloc_acc = '0;
         length_acc = '0;
         run_sum = CK_INIT;
         name_cnt = 0;
         sum_hi = '0;
      end
      case (phase)
         PH_FIXED: begin
            if (fixed_pos < MAGIC_LEN && b != HDR_MAGIC[fixed_pos]) begin
               close_header(ST_BAD_MAGIC, 1'b0, 1'b0);
            end else begin
               if (fixed_pos >= ALLOC_END) length_acc = {length_acc[15:0], b};
               else if (fixed_pos >= MAGIC_LEN) alloc_acc = {alloc_acc[15:0], b};
               run_sum = checksum_step(run_sum, b);
               fixed_pos++;
               if (fixed_pos >= FIXED_BYTES) begin
                  phase = PH_NAME;
                  name_cnt = 0;
               end
            end
         end
         PH_NAME: begin
            // terminator is not part of the checksum
            if (b == 8'h00) begin
               phase = PH_CKHI;
            end else if (name_cnt >= NAME_MAX) begin
               close_header(ST_NAME_UNTERM, 1'b0, 1'b1);
            end else begin
               run_sum = checksum_step(run_sum, b);
               name_cnt++;
               r = '0;
               r.kind = KIND_CHAR;
               r.name_char = b;
               expected_results.push_back(r);
            end
         end
         PH_CKHI: begin
            sum_hi = b;
            if (b != run_sum[15:8]) close_header(ST_CK_MISMATCH, 1'b1, 1'b1);
            else phase = PH_CKLO;
         end
         PH_CKLO: begin
            close_header(({sum_hi, b} == run_sum) ? ST_OK : ST_CK_MISMATCH, 1'b1, 1'b1);
         end
         default: begin
            // idle: bytes without a start flag are dropped
            phase = PH_IDLE;
         end
      endcase
   endtask

   task automatic check_result_beat();
      rsp_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("beat with nothing expected, kind", rsp_tuser, 0);
         return;
      end
      want = expected_results.pop_front();
      if (rsp_tuser != want.kind) report_mismatch("item_kind", rsp_tuser, want.kind);
      if (rsp_tdata[7:0] != want.name_char)
         report_mismatch("name_char", rsp_tdata[7:0], want.name_char);
      if (rsp_tdata[9:8] != want.status)
         report_mismatch("header_status", rsp_tdata[9:8], want.status);
      if (rsp_tdata[33:10] != want.alloc_sectors)
         report_mismatch("alloc_sectors", rsp_tdata[33:10], want.alloc_sectors);
      if (rsp_tdata[57:34] != want.file_bytes)
         report_mismatch("file_bytes", rsp_tdata[57:34], want.file_bytes);
      if (rsp_tdata[61:58] != want.name_count)
         report_mismatch("name_count", rsp_tdata[61:58], want.name_count);
      if (rsp_tdata[66:62] != want.data_offset)
         report_mismatch("data_offset", rsp_tdata[66:62], want.data_offset);
      if (rsp_tdata[86:67] != want.sectors_in_use)
         report_mismatch("sectors_in_use", rsp_tdata[86:67], want.sectors_in_use);
      if (rsp_tdata[87] !== 1'b0) report_mismatch("pad bit", rsp_tdata[87], 0);
   endtask

   // field values biased towards the extremes
   function automatic logic [23:0] pick_wide();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return 24'($urandom_range(0, 255));
         default: return 24'($urandom);
      endcase
   endfunction

   // build one sector header, damage it as asked and queue it with some ignored bytes after
   task automatic queue_sector(input fault_kind_type fault, input int nlen,
                               input logic [23:0] alloc, input logic [23:0] flen,
                               input int tail);
      logic [7:0]  img[$];
      logic [15:0] ck;
      int          stop;
      ck = CK_INIT;
      for (int i = 0; i < MAGIC_LEN; i++) img.push_back(HDR_MAGIC[i]);
      img.push_back(alloc[23:16]);
      img.push_back(alloc[15:8]);
      img.push_back(alloc[7:0]);
      img.push_back(flen[23:16]);
      img.push_back(flen[15:8]);
      img.push_back(flen[7:0]);
      // one character too many and no terminator
      if (fault == FLT_UNTERM) nlen = NAME_MAX + 1;
      for (int i = 0; i < nlen; i++) img.push_back(8'($urandom_range(1, 255)));
      foreach (img[i]) ck = checksum_step(ck, img[i]);
      if (fault != FLT_UNTERM) begin
         img.push_back(8'h00);
         img.push_back(ck[15:8]);
         img.push_back(ck[7:0]);
      end
      case (fault)
         FLT_MAGIC: begin
            stop = $urandom_range(0, MAGIC_LEN - 1);
            img[stop] ^= 8'($urandom_range(1, 255));
            stop++;
         end
         FLT_CK_HI: begin
            img[img.size() - 2] ^= 8'($urandom_range(1, 255));
            stop = img.size() - 1;
         end
         FLT_CK_LO: begin
            img[img.size() - 1] ^= 8'($urandom_range(1, 255));
            stop = img.size();
         end
         // cut short, the next start flag restarts the parse
         FLT_CUT: stop = $urandom_range(1, img.size() - 1);
         default: stop = img.size();
      endcase
      for (int i = 0; i < stop; i++) pending_bytes.push_back('{data: img[i], start: (i == 0)});
      fed_bytes += stop + tail;
      repeat (tail) pending_bytes.push_back('{data: 8'($urandom), start: 1'b0});
   endtask

   task automatic queue_random_sector();
      int          roll;
      int          nlen;
      int          n;
      fault_kind_type fault;
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: nlen = 0;
         1: nlen = NAME_MAX;
         default: nlen = $urandom_range(0, NAME_MAX);
      endcase
      if (roll >= 92) begin
         // noise with stray start flags
         n = $urandom_range(1, 12);
         repeat (n)
            pending_bytes.push_back('{data: 8'($urandom), start: ($urandom_range(0, 4) == 0)});
         fed_bytes += n;
      end else begin
         if (roll < 45) fault = FLT_NONE;
         else if (roll < 54) fault = FLT_MAGIC;
         else if (roll < 63) fault = FLT_UNTERM;
         else if (roll < 72) fault = FLT_CK_HI;
         else if (roll < 81) fault = FLT_CK_LO;
         else fault = FLT_CUT;
         queue_sector(fault, nlen, pick_wide(), pick_wide(),
                      (fault == FLT_CUT) ? 0 : int'($urandom_range(0, 2)));
      end
   endtask

   // sender waits until every queued byte is taken and every result has come
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   // sampling, prediction and checking on the rising edge
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end else begin
         req_fire = !reset && req_tvalid && req_tready;
         if (req_fire) parse_byte(req_tdata, req_tuser);
         if (!reset && rsp_tvalid && rsp_tready) check_result_beat();
      end
   end

   // byte driver, changes inputs on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // beat still on offer, hold it
      end else if (send_gap != 0) begin
         send_gap <= send_gap - 1;
         req_tvalid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         // idle burst
         send_gap <= $urandom_range(0, 2);
         req_tvalid <= 1'b0;
      end else begin
         next_beat = pending_bytes.pop_front();
         req_tdata <= next_beat.data;
         req_tuser <= next_beat.start;
         req_tvalid <= 1'b1;
      end
   end

   // result receiver: long hold-offs on request, otherwise short random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_granted != holds_asked) begin
         holds_granted <= holds_granted + 1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: stray byte while idle, empty header, bad magic, restart mid-header
      pending_bytes.push_back('{data: 8'hA5, start: 1'b0});
      queue_sector(FLT_NONE, 0, '1, '0, 2);
      queue_sector(FLT_MAGIC, 0, '0, '0, 0);
      queue_sector(FLT_CUT, NAME_MAX, '1, '1, 0);
      queue_sector(FLT_NONE, NAME_MAX, '0, '1, 0);
      wait_drained();

      // random headers with idling on both sides
      while (fed_bytes < ITEM_GOAL / 2) queue_random_sector();
      wait_drained();

      // receiver holds off while long names keep coming, so the block backs up
      holds_asked++;
      repeat (5) queue_sector(FLT_NONE, NAME_MAX, pick_wide(), pick_wide(), 0);
      wait_drained();

      while (fed_bytes < ITEM_GOAL * 4 / 5) queue_random_sector();
      wait_drained();

      // last stretch at full rate
      idle_on = 1'b0;
      while (fed_bytes < ITEM_GOAL) queue_random_sector();
      wait_drained();

      // let any stray beat show up
      repeat (12) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
